>>> rtl/spi_pkg.sv
package spi_pkg;

    // Default geometry of the datapath
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    // Fixed port widths
    localparam int IN_BITS  = 16;
    localparam int OUT_BITS = 32;
    localparam int CNT_BITS = 2;

    // Control that travels with each transaction down the pipeline
    typedef struct packed {
        logic                is_cross; // result is a line crossing
        logic [CNT_BITS-1:0] count;    // number of common points
        logic                neg_x;    // x direction of segment a is negative
        logic                neg_y;    // y direction of segment a is negative
    } t_ctl;

endpackage

>>> rtl/spi_setup.sv
module spi_setup #(
    parameter int CB = spi_pkg::COORD_BITS_DEF,
    parameter int FB = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [spi_pkg::IN_BITS-1:0] i_a_start_x,
    input  logic [spi_pkg::IN_BITS-1:0] i_a_start_y,
    input  logic [spi_pkg::IN_BITS-1:0] i_a_end_x,
    input  logic [spi_pkg::IN_BITS-1:0] i_a_end_y,
    input  logic [spi_pkg::IN_BITS-1:0] i_b_start_x,
    input  logic [spi_pkg::IN_BITS-1:0] i_b_start_y,
    input  logic [spi_pkg::IN_BITS-1:0] i_b_end_x,
    input  logic [spi_pkg::IN_BITS-1:0] i_b_end_y,
    output logic                        o_valid,
    output spi_pkg::t_ctl               o_ctl,
    output logic signed [CB-1:0]        o_p0x,
    output logic signed [CB-1:0]        o_p0y,
    output logic signed [CB-1:0]        o_p1x,
    output logic signed [CB-1:0]        o_p1y,
    output logic [2*CB:0]               o_den,
    output logic [2*CB:0]               o_rx,
    output logic [2*CB:0]               o_ry,
    output logic [CB-1:0]               o_lowx,
    output logic [CB-1:0]               o_lowy
);

    localparam int IW = spi_pkg::IN_BITS;
    localparam int SW = 2 * CB + 3;
    localparam int DW = 2 * CB + 1;
    localparam int PW = 3 * CB + 1;

    // ---------------- stage 1: reinterpret coordinates ----------------
    logic [IW-1:0]         raw [8];
    logic [CB+IW-1:0]      n1_ext [8];
    logic signed [CB-1:0]  r1_c [8];
    logic                  r1_v;

    assign raw[0] = i_a_start_x;
    assign raw[1] = i_a_start_y;
    assign raw[2] = i_a_end_x;
    assign raw[3] = i_a_end_y;
    assign raw[4] = i_b_start_x;
    assign raw[5] = i_b_start_y;
    assign raw[6] = i_b_end_x;
    assign raw[7] = i_b_end_y;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            n1_ext[i] = {{CB{1'b0}}, raw[i]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 8; i++) begin
                r1_c[i] <= n1_ext[i][CB-1:0];
            end
        end
    end

    // ---------------- stage 2: differences, boxes, equalities ----------------
    logic signed [CB-1:0] axmin, axmax, aymin, aymax, bxmin, bxmax, bymin, bymax;
    logic                 n2_disj;
    logic [3:0]           n2_inbox;   // a0 in box b, a1 in box b, b0 in box a, b1 in box a
    logic [15:0]          n2_eqm;     // point equality matrix, index {i, j}

    assign axmin = (r1_c[0] < r1_c[2]) ? r1_c[0] : r1_c[2];
    assign axmax = (r1_c[0] > r1_c[2]) ? r1_c[0] : r1_c[2];
    assign aymin = (r1_c[1] < r1_c[3]) ? r1_c[1] : r1_c[3];
    assign aymax = (r1_c[1] > r1_c[3]) ? r1_c[1] : r1_c[3];
    assign bxmin = (r1_c[4] < r1_c[6]) ? r1_c[4] : r1_c[6];
    assign bxmax = (r1_c[4] > r1_c[6]) ? r1_c[4] : r1_c[6];
    assign bymin = (r1_c[5] < r1_c[7]) ? r1_c[5] : r1_c[7];
    assign bymax = (r1_c[5] > r1_c[7]) ? r1_c[5] : r1_c[7];

    assign n2_disj = (axmax < bxmin) || (aymax < bymin) ||
                     (bymax < aymin) || (bxmax < axmin);

    assign n2_inbox[0] = (r1_c[0] >= bxmin) && (r1_c[0] <= bxmax) &&
                         (r1_c[1] >= bymin) && (r1_c[1] <= bymax);
    assign n2_inbox[1] = (r1_c[2] >= bxmin) && (r1_c[2] <= bxmax) &&
                         (r1_c[3] >= bymin) && (r1_c[3] <= bymax);
    assign n2_inbox[2] = (r1_c[4] >= axmin) && (r1_c[4] <= axmax) &&
                         (r1_c[5] >= aymin) && (r1_c[5] <= aymax);
    assign n2_inbox[3] = (r1_c[6] >= axmin) && (r1_c[6] <= axmax) &&
                         (r1_c[7] >= aymin) && (r1_c[7] <= aymax);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n2_eqm[i*4+j] = (r1_c[2*i] == r1_c[2*j]) && (r1_c[2*i+1] == r1_c[2*j+1]);
            end
        end
    end

    logic                 r2_v;
    logic signed [CB:0]   r2_dax, r2_day, r2_dbx, r2_dby, r2_ex, r2_ey;
    logic                 r2_disj;
    logic [3:0]           r2_inbox;
    logic [15:0]          r2_eqm;
    logic signed [CB-1:0] r2_c [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_dax   <= (CB+1)'(r1_c[2]) - (CB+1)'(r1_c[0]);
            r2_day   <= (CB+1)'(r1_c[3]) - (CB+1)'(r1_c[1]);
            r2_dbx   <= (CB+1)'(r1_c[6]) - (CB+1)'(r1_c[4]);
            r2_dby   <= (CB+1)'(r1_c[7]) - (CB+1)'(r1_c[5]);
            r2_ex    <= (CB+1)'(r1_c[4]) - (CB+1)'(r1_c[0]);
            r2_ey    <= (CB+1)'(r1_c[5]) - (CB+1)'(r1_c[1]);
            r2_disj  <= n2_disj;
            r2_inbox <= n2_inbox;
            r2_eqm   <= n2_eqm;
            r2_c     <= r1_c;
        end
    end

    // ---------------- stage 3: cross-product terms ----------------
    logic                  r3_v;
    logic signed [2*CB+1:0] r3_pd1, r3_pd2, r3_pt1, r3_pt2, r3_pu1, r3_pu2;
    logic signed [CB:0]    r3_dax, r3_day;
    logic                  r3_disj;
    logic [3:0]            r3_inbox;
    logic [15:0]           r3_eqm;
    logic signed [CB-1:0]  r3_c [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (i_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pd1   <= r2_dax * r2_dby;
            r3_pd2   <= r2_day * r2_dbx;
            r3_pt1   <= r2_ex * r2_dby;
            r3_pt2   <= r2_ey * r2_dbx;
            r3_pu1   <= r2_ex * r2_day;
            r3_pu2   <= r2_ey * r2_dax;
            r3_dax   <= r2_dax;
            r3_day   <= r2_day;
            r3_disj  <= r2_disj;
            r3_inbox <= r2_inbox;
            r3_eqm   <= r2_eqm;
            r3_c     <= r2_c;
        end
    end

    // ---------------- stage 4: determinant and numerators, sign-normalised ----------------
    logic signed [SW-1:0] n4_den, n4_tn, n4_un;
    logic signed [CB:0]   n4_ndax, n4_nday;

    assign n4_den  = SW'(r3_pd1) - SW'(r3_pd2);
    assign n4_tn   = SW'(r3_pt1) - SW'(r3_pt2);
    assign n4_un   = SW'(r3_pu1) - SW'(r3_pu2);
    assign n4_ndax = -r3_dax;
    assign n4_nday = -r3_day;

    logic                 r4_v;
    logic signed [SW-1:0] r4_den, r4_tn, r4_un;
    logic [CB-1:0]        r4_mdx, r4_mdy;
    logic                 r4_negx, r4_negy;
    logic                 r4_disj;
    logic [3:0]           r4_inbox;
    logic [15:0]          r4_eqm;
    logic signed [CB-1:0] r4_c [8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (i_en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (n4_den < 0) begin
                r4_den <= -n4_den;
                r4_tn  <= -n4_tn;
                r4_un  <= -n4_un;
            end else begin
                r4_den <= n4_den;
                r4_tn  <= n4_tn;
                r4_un  <= n4_un;
            end
            r4_mdx   <= r3_dax[CB] ? n4_ndax[CB-1:0] : r3_dax[CB-1:0];
            r4_mdy   <= r3_day[CB] ? n4_nday[CB-1:0] : r3_day[CB-1:0];
            r4_negx  <= r3_dax[CB];
            r4_negy  <= r3_day[CB];
            r4_disj  <= r3_disj;
            r4_inbox <= r3_inbox;
            r4_eqm   <= r3_eqm;
            r4_c     <= r3_c;
        end
    end

    // ---------------- stage 5: classify, pick points, partial products ----------------
    logic          n5_den_nz, n5_cross_ok, n5_tz, n5_uz, n5_adeg, n5_bdeg;
    logic [3:0]    n5_ok;
    logic [1:0]    n5_k0, n5_k1, n5_n;
    spi_pkg::t_ctl n5_ctl;

    assign n5_den_nz   = (r4_den != '0);
    assign n5_cross_ok = !r4_tn[SW-1] && (r4_tn <= r4_den) &&
                         !r4_un[SW-1] && (r4_un <= r4_den);
    assign n5_tz   = (r4_tn == '0);
    assign n5_uz   = (r4_un == '0);
    assign n5_adeg = r4_eqm[0*4+1];
    assign n5_bdeg = r4_eqm[2*4+3];

    // each candidate lies on its own segment; test it against the other one
    assign n5_ok[0] = n5_bdeg ? r4_eqm[0*4+2] : (n5_tz && r4_inbox[0]);
    assign n5_ok[1] = n5_bdeg ? r4_eqm[1*4+2] : (n5_tz && r4_inbox[1]);
    assign n5_ok[2] = n5_adeg ? r4_eqm[2*4+0] : (n5_uz && r4_inbox[2]);
    assign n5_ok[3] = n5_adeg ? r4_eqm[3*4+0] : (n5_uz && r4_inbox[3]);

    // keep the first two distinct candidates in order
    always_comb begin
        n5_n  = 2'd0;
        n5_k0 = 2'd0;
        n5_k1 = 2'd0;
        for (int i = 0; i < 4; i++) begin
            if (n5_ok[i]) begin
                if (n5_n == 2'd0) begin
                    n5_k0 = 2'(i);
                    n5_n  = 2'd1;
                end else if (n5_n == 2'd1 && !r4_eqm[{n5_k0, 2'(i)}]) begin
                    n5_k1 = 2'(i);
                    n5_n  = 2'd2;
                end
            end
        end
    end

    always_comb begin
        n5_ctl.neg_x    = r4_negx;
        n5_ctl.neg_y    = r4_negy;
        n5_ctl.is_cross = !r4_disj && n5_den_nz && n5_cross_ok;
        priority if (r4_disj) begin
            n5_ctl.count = 2'd0;
        end else if (n5_den_nz) begin
            n5_ctl.count = {1'b0, n5_cross_ok};
        end else begin
            n5_ctl.count = n5_n;
        end
    end

    logic                 r5_v;
    spi_pkg::t_ctl        r5_ctl;
    logic signed [CB-1:0] r5_p0x, r5_p0y, r5_p1x, r5_p1y;
    logic [DW-1:0]        r5_den;
    logic [2*CB:0]        r5_plox, r5_ploy;
    logic [2*CB-1:0]      r5_phix, r5_phiy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (i_en) begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r5_ctl  <= n5_ctl;
            // the crossing takes segment a's start as its base point
            r5_p0x  <= n5_ctl.is_cross ? r4_c[0] : r4_c[{n5_k0, 1'b0}];
            r5_p0y  <= n5_ctl.is_cross ? r4_c[1] : r4_c[{n5_k0, 1'b1}];
            r5_p1x  <= r4_c[{n5_k1, 1'b0}];
            r5_p1y  <= r4_c[{n5_k1, 1'b1}];
            r5_den  <= r4_den[DW-1:0];
            r5_plox <= r4_tn[CB:0] * r4_mdx;
            r5_phix <= r4_tn[2*CB:CB+1] * r4_mdx;
            r5_ploy <= r4_tn[CB:0] * r4_mdy;
            r5_phiy <= r4_tn[2*CB:CB+1] * r4_mdy;
        end
    end

    // ---------------- stage 6: full product, split for the divider ----------------
    logic [PW-1:0] n6_px, n6_py;

    assign n6_px = PW'(r5_plox) + (PW'(r5_phix) << (CB + 1));
    assign n6_py = PW'(r5_ploy) + (PW'(r5_phiy) << (CB + 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ctl  <= r5_ctl;
            o_p0x  <= r5_p0x;
            o_p0y  <= r5_p0y;
            o_p1x  <= r5_p1x;
            o_p1y  <= r5_p1y;
            o_den  <= r5_den;
            o_rx   <= n6_px[PW-1:CB];
            o_ry   <= n6_py[PW-1:CB];
            o_lowx <= n6_px[CB-1:0];
            o_lowy <= n6_py[CB-1:0];
        end
    end

endmodule

>>> rtl/spi_div.sv
module spi_div #(
    parameter int CB = spi_pkg::COORD_BITS_DEF,
    parameter int FB = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  spi_pkg::t_ctl         i_ctl,
    input  logic signed [CB-1:0]  i_p0x,
    input  logic signed [CB-1:0]  i_p0y,
    input  logic signed [CB-1:0]  i_p1x,
    input  logic signed [CB-1:0]  i_p1y,
    input  logic [2*CB:0]         i_den,
    input  logic [2*CB:0]         i_rx,
    input  logic [2*CB:0]         i_ry,
    input  logic [CB-1:0]         i_lowx,
    input  logic [CB-1:0]         i_lowy,
    output logic                  o_valid,
    output spi_pkg::t_ctl         o_ctl,
    output logic signed [CB-1:0]  o_p0x,
    output logic signed [CB-1:0]  o_p0y,
    output logic signed [CB-1:0]  o_p1x,
    output logic signed [CB-1:0]  o_p1y,
    output logic [CB+FB:0]        o_qx,
    output logic [CB+FB:0]        o_qy,
    output logic                  o_remnz_x,
    output logic                  o_remnz_y
);

    localparam int QW = CB + FB + 1;
    localparam int DW = 2 * CB + 1;

    // stage inputs (w_) and stage registers (r_), one entry per quotient bit
    logic                 w_v   [QW];
    spi_pkg::t_ctl        w_ctl [QW];
    logic [DW-1:0]        w_den [QW];
    logic [DW-1:0]        w_rx  [QW];
    logic [DW-1:0]        w_ry  [QW];
    logic [QW-1:0]        w_lx  [QW];
    logic [QW-1:0]        w_ly  [QW];
    logic [QW-1:0]        w_qx  [QW];
    logic [QW-1:0]        w_qy  [QW];
    logic signed [CB-1:0] w_pt  [QW][4];

    logic                 r_v   [QW];
    spi_pkg::t_ctl        r_ctl [QW];
    logic [DW-1:0]        r_den [QW];
    logic [DW-1:0]        r_rx  [QW];
    logic [DW-1:0]        r_ry  [QW];
    logic [QW-1:0]        r_lx  [QW];
    logic [QW-1:0]        r_ly  [QW];
    logic [QW-1:0]        r_qx  [QW];
    logic [QW-1:0]        r_qy  [QW];
    logic signed [CB-1:0] r_pt  [QW][4];

    // dividend bits still to come: product low bits, then the fraction bits
    assign w_v[0]     = i_valid;
    assign w_ctl[0]   = i_ctl;
    assign w_den[0]   = i_den;
    assign w_rx[0]    = i_rx;
    assign w_ry[0]    = i_ry;
    assign w_lx[0]    = {i_lowx, {(FB + 1){1'b0}}};
    assign w_ly[0]    = {i_lowy, {(FB + 1){1'b0}}};
    assign w_qx[0]    = '0;
    assign w_qy[0]    = '0;
    assign w_pt[0][0] = i_p0x;
    assign w_pt[0][1] = i_p0y;
    assign w_pt[0][2] = i_p1x;
    assign w_pt[0][3] = i_p1y;

    genvar j;
    for (j = 0; j < QW; j++) begin : g_stage
        logic [DW:0] x_try, x_sub, y_try, y_sub;
        logic        x_ge, y_ge;

        if (j > 0) begin : g_link
            assign w_v[j]   = r_v[j-1];
            assign w_ctl[j] = r_ctl[j-1];
            assign w_den[j] = r_den[j-1];
            assign w_rx[j]  = r_rx[j-1];
            assign w_ry[j]  = r_ry[j-1];
            assign w_lx[j]  = r_lx[j-1];
            assign w_ly[j]  = r_ly[j-1];
            assign w_qx[j]  = r_qx[j-1];
            assign w_qy[j]  = r_qy[j-1];
            assign w_pt[j]  = r_pt[j-1];
        end

        // one restoring step per coordinate
        assign x_try = {w_rx[j], w_lx[j][QW-1]};
        assign y_try = {w_ry[j], w_ly[j][QW-1]};
        assign x_sub = x_try - {1'b0, w_den[j]};
        assign y_sub = y_try - {1'b0, w_den[j]};
        assign x_ge  = (x_try >= {1'b0, w_den[j]});
        assign y_ge  = (y_try >= {1'b0, w_den[j]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= w_v[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ctl[j] <= w_ctl[j];
                r_den[j] <= w_den[j];
                r_pt[j]  <= w_pt[j];
                r_rx[j]  <= x_ge ? x_sub[DW-1:0] : x_try[DW-1:0];
                r_ry[j]  <= y_ge ? y_sub[DW-1:0] : y_try[DW-1:0];
                r_lx[j]  <= w_lx[j] << 1;
                r_ly[j]  <= w_ly[j] << 1;
                r_qx[j]  <= {w_qx[j][QW-2:0], x_ge};
                r_qy[j]  <= {w_qy[j][QW-2:0], y_ge};
            end
        end
    end

    assign o_valid   = r_v[QW-1];
    assign o_ctl     = r_ctl[QW-1];
    assign o_p0x     = r_pt[QW-1][0];
    assign o_p0y     = r_pt[QW-1][1];
    assign o_p1x     = r_pt[QW-1][2];
    assign o_p1y     = r_pt[QW-1][3];
    assign o_qx      = r_qx[QW-1];
    assign o_qy      = r_qy[QW-1];
    assign o_remnz_x = |r_rx[QW-1];
    assign o_remnz_y = |r_ry[QW-1];

endmodule

>>> rtl/spi_out.sv
module spi_out #(
    parameter int CB = spi_pkg::COORD_BITS_DEF,
    parameter int FB = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_stall,
    input  logic                          i_valid,
    input  spi_pkg::t_ctl                 i_ctl,
    input  logic signed [CB-1:0]          i_p0x,
    input  logic signed [CB-1:0]          i_p0y,
    input  logic signed [CB-1:0]          i_p1x,
    input  logic signed [CB-1:0]          i_p1y,
    input  logic [CB+FB:0]                i_qx,
    input  logic [CB+FB:0]                i_qy,
    input  logic                          i_remnz_x,
    input  logic                          i_remnz_y,
    output logic                          o_en,
    output logic                          o_valid,
    output logic [spi_pkg::CNT_BITS-1:0]  o_point_count,
    output logic [spi_pkg::OUT_BITS-1:0]  o_first_x,
    output logic [spi_pkg::OUT_BITS-1:0]  o_first_y,
    output logic [spi_pkg::OUT_BITS-1:0]  o_second_x,
    output logic [spi_pkg::OUT_BITS-1:0]  o_second_y
);

    localparam int QW = CB + FB + 1;
    localparam int OW = spi_pkg::OUT_BITS;
    localparam int FW = OW + CB + FB;

    // the whole pipeline moves unless a held result blocks the output
    assign o_en = !o_valid || !i_stall;

    // ---------------- rounding stage: half the extended quotient ----------------
    logic [QW:0] n_kpx, n_kpy;

    // towards plus infinity on a tie: up for a positive step, down only on a
    // strict excess for a negative one
    assign n_kpx = {1'b0, i_qx} +
                   (QW+1)'(i_ctl.neg_x ? (i_remnz_x & i_qx[0]) : 1'b1);
    assign n_kpy = {1'b0, i_qy} +
                   (QW+1)'(i_ctl.neg_y ? (i_remnz_y & i_qy[0]) : 1'b1);

    logic                 r_a_valid;
    spi_pkg::t_ctl        r_a_ctl;
    logic signed [CB-1:0] r_a_p0x, r_a_p0y, r_a_p1x, r_a_p1y;
    logic [QW-1:0]        r_a_magx, r_a_magy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_en) begin
            r_a_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r_a_ctl  <= i_ctl;
            r_a_p0x  <= i_p0x;
            r_a_p0y  <= i_p0y;
            r_a_p1x  <= i_p1x;
            r_a_p1y  <= i_p1y;
            r_a_magx <= n_kpx[QW:1];
            r_a_magy <= n_kpy[QW:1];
        end
    end

    // ---------------- output register: fixed-point assembly ----------------
    logic [FW-1:0] n_b0x, n_b0y, n_b1x, n_b1y, n_cx, n_cy;
    logic [OW-1:0] n_fx, n_fy, n_sx, n_sy;

    assign n_b0x = FW'(r_a_p0x) << FB;
    assign n_b0y = FW'(r_a_p0y) << FB;
    assign n_b1x = FW'(r_a_p1x) << FB;
    assign n_b1y = FW'(r_a_p1y) << FB;
    assign n_cx  = r_a_ctl.neg_x ? (n_b0x - FW'(r_a_magx)) : (n_b0x + FW'(r_a_magx));
    assign n_cy  = r_a_ctl.neg_y ? (n_b0y - FW'(r_a_magy)) : (n_b0y + FW'(r_a_magy));

    always_comb begin
        n_fx = '0;
        n_fy = '0;
        n_sx = '0;
        n_sy = '0;
        if (r_a_ctl.count != 2'd0) begin
            n_fx = r_a_ctl.is_cross ? n_cx[OW-1:0] : n_b0x[OW-1:0];
            n_fy = r_a_ctl.is_cross ? n_cy[OW-1:0] : n_b0y[OW-1:0];
        end
        if (r_a_ctl.count == 2'd2) begin
            n_sx = n_b1x[OW-1:0];
            n_sy = n_b1y[OW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (o_en) begin
            o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            o_point_count <= r_a_ctl.count;
            o_first_x     <= n_fx;
            o_first_y     <= n_fy;
            o_second_x    <= n_sx;
            o_second_y    <= n_sy;
        end
    end

endmodule

>>> rtl/segment_pair_intersection_unit.sv
// Pipeline: six setup stages, one divider stage per quotient bit, a rounding stage
// and the output register.
// Throughput: one transaction per cycle; the pipeline holds as a whole while a
// result waits on i_stall.
// Reset: synchronous, active low on i_rst_n; clears every valid bit, data is kept.
module segment_pair_intersection_unit #(
    parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = spi_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [spi_pkg::IN_BITS-1:0]   i_a_start_x,
    input  logic [spi_pkg::IN_BITS-1:0]   i_a_start_y,
    input  logic [spi_pkg::IN_BITS-1:0]   i_a_end_x,
    input  logic [spi_pkg::IN_BITS-1:0]   i_a_end_y,
    input  logic [spi_pkg::IN_BITS-1:0]   i_b_start_x,
    input  logic [spi_pkg::IN_BITS-1:0]   i_b_start_y,
    input  logic [spi_pkg::IN_BITS-1:0]   i_b_end_x,
    input  logic [spi_pkg::IN_BITS-1:0]   i_b_end_y,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [spi_pkg::CNT_BITS-1:0]  o_point_count,
    output logic [spi_pkg::OUT_BITS-1:0]  o_first_x,
    output logic [spi_pkg::OUT_BITS-1:0]  o_first_y,
    output logic [spi_pkg::OUT_BITS-1:0]  o_second_x,
    output logic [spi_pkg::OUT_BITS-1:0]  o_second_y
);

    localparam int CB = COORD_BITS;
    localparam int FB = FRAC_BITS;

    logic                 en;

    logic                 s_valid;
    spi_pkg::t_ctl        s_ctl;
    logic signed [CB-1:0] s_p0x, s_p0y, s_p1x, s_p1y;
    logic [2*CB:0]        s_den, s_rx, s_ry;
    logic [CB-1:0]        s_lowx, s_lowy;

    logic                 d_valid;
    spi_pkg::t_ctl        d_ctl;
    logic signed [CB-1:0] d_p0x, d_p0y, d_p1x, d_p1y;
    logic [CB+FB:0]       d_qx, d_qy;
    logic                 d_remnz_x, d_remnz_y;

    assign o_stall = !en;

    // operand setup: differences, cross products, candidate selection
    spi_setup #(
        .CB (CB),
        .FB (FB)
    ) u_setup (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (i_valid),
        .i_a_start_x (i_a_start_x),
        .i_a_start_y (i_a_start_y),
        .i_a_end_x   (i_a_end_x),
        .i_a_end_y   (i_a_end_y),
        .i_b_start_x (i_b_start_x),
        .i_b_start_y (i_b_start_y),
        .i_b_end_x   (i_b_end_x),
        .i_b_end_y   (i_b_end_y),
        .o_valid     (s_valid),
        .o_ctl       (s_ctl),
        .o_p0x       (s_p0x),
        .o_p0y       (s_p0y),
        .o_p1x       (s_p1x),
        .o_p1y       (s_p1y),
        .o_den       (s_den),
        .o_rx        (s_rx),
        .o_ry        (s_ry),
        .o_lowx      (s_lowx),
        .o_lowy      (s_lowy)
    );

    // pipelined long division of the crossing offsets
    spi_div #(
        .CB (CB),
        .FB (FB)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_valid   (s_valid),
        .i_ctl     (s_ctl),
        .i_p0x     (s_p0x),
        .i_p0y     (s_p0y),
        .i_p1x     (s_p1x),
        .i_p1y     (s_p1y),
        .i_den     (s_den),
        .i_rx      (s_rx),
        .i_ry      (s_ry),
        .i_lowx    (s_lowx),
        .i_lowy    (s_lowy),
        .o_valid   (d_valid),
        .o_ctl     (d_ctl),
        .o_p0x     (d_p0x),
        .o_p0y     (d_p0y),
        .o_p1x     (d_p1x),
        .o_p1y     (d_p1y),
        .o_qx      (d_qx),
        .o_qy      (d_qy),
        .o_remnz_x (d_remnz_x),
        .o_remnz_y (d_remnz_y)
    );

    // rounding and the output register
    spi_out #(
        .CB (CB),
        .FB (FB)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_stall       (i_stall),
        .i_valid       (d_valid),
        .i_ctl         (d_ctl),
        .i_p0x         (d_p0x),
        .i_p0y         (d_p0y),
        .i_p1x         (d_p1x),
        .i_p1y         (d_p1y),
        .i_qx          (d_qx),
        .i_qy          (d_qy),
        .i_remnz_x     (d_remnz_x),
        .i_remnz_y     (d_remnz_y),
        .o_en          (en),
        .o_valid       (o_valid),
        .o_point_count (o_point_count),
        .o_first_x     (o_first_x),
        .o_first_y     (o_first_y),
        .o_second_x    (o_second_x),
        .o_second_y    (o_second_y)
    );

endmodule

>>> test/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC      = spi_pkg::FRAC_BITS_DEF;
    localparam int N_RANDOM  = 1250;
    localparam int MAX_CYC   = 400000;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic [15:0] a_start_x, a_start_y, a_end_x, a_end_y;
        logic [15:0] b_start_x, b_start_y, b_end_x, b_end_y;
    } t_seg_pair;

    typedef struct packed {
        logic [1:0]  point_count;
        logic [31:0] first_x, first_y, second_x, second_y;
    } t_meet;

    typedef struct {
        t_seg_pair pair;
        bit        drain;   // hold back until the pipeline has emptied
    } t_job;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall, o_valid;
    t_seg_pair   cur = '0;
    logic [1:0]  o_point_count;
    logic [31:0] o_first_x, o_first_y, o_second_x, o_second_y;

    t_job  job_q[$];
    t_meet meet_q[$];
    int    n_errors = 0;
    int    n_sent = 0;
    int    n_seen = 0;
    int    n_cross = 0;
    int    n_two = 0;
    int    cycles = 0;
    bit    stim_done = 0;

    segment_pair_intersection_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_a_start_x(cur.a_start_x), .i_a_start_y(cur.a_start_y),
        .i_a_end_x(cur.a_end_x), .i_a_end_y(cur.a_end_y),
        .i_b_start_x(cur.b_start_x), .i_b_start_y(cur.b_start_y),
        .i_b_end_x(cur.b_end_x), .i_b_end_y(cur.b_end_y),
        .o_valid(o_valid), .i_stall(i_stall), .o_point_count(o_point_count),
        .o_first_x(o_first_x), .o_first_y(o_first_y),
        .o_second_x(o_second_x), .o_second_y(o_second_y)
    );

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint cross2(longint ax, longint ay, longint bx, longint by);
        return ax * by - ay * bx;
    endfunction

    // Exact point-on-segment test; a zero-length segment holds only its own point
    function automatic bit on_segment(longint s0x, longint s0y, longint s1x, longint s1y,
                                      longint px, longint py);
        if (s0x == s1x && s0y == s1y)
            return px == s0x && py == s0y;
        if (cross2(s1x - s0x, s1y - s0y, px - s0x, py - s0y) != 0)
            return 0;
        return px >= ((s0x < s1x) ? s0x : s1x) && px <= ((s0x > s1x) ? s0x : s1x) &&
               py >= ((s0y < s1y) ? s0y : s1y) && py <= ((s0y > s1y) ? s0y : s1y);
    endfunction

    // base + (tn/den)*d in fixed point, nearest, ties toward plus infinity
    function automatic logic [31:0] crossing_coord(longint base, longint d, longint tn,
                                                   longint den);
        logic [127:0] num, q, rem;
        logic [63:0]  res, md;
        md  = (d < 0) ? 64'(-d) : 64'(d);
        num = (128'(tn) * 128'(md)) << (FRAC + 1);
        q   = num / 128'(den);
        rem = num % 128'(den);
        res = 64'(base) << FRAC;
        if (d >= 0)
            res = res + 64'((q + 1) >> 1);
        else
            res = res - 64'((q + ((rem != 0 && q[0]) ? 1 : 0)) >> 1);
        return res[31:0];
    endfunction

    function automatic t_meet predict_meet(t_seg_pair p);
        t_meet  m;
        longint px[4], py[4], kx[2], ky[2];
        longint dax, day, dbx, dby, den, tn, un, ex, ey;
        logic [63:0] w;
        int     n;
        bit     dup;
        m = '0;
        n = 0;
        px[0] = $signed(p.a_start_x); py[0] = $signed(p.a_start_y);
        px[1] = $signed(p.a_end_x);   py[1] = $signed(p.a_end_y);
        px[2] = $signed(p.b_start_x); py[2] = $signed(p.b_start_y);
        px[3] = $signed(p.b_end_x);   py[3] = $signed(p.b_end_y);
        // bounding boxes apart
        if (((px[0] > px[1]) ? px[0] : px[1]) < ((px[2] < px[3]) ? px[2] : px[3]) ||
            ((py[0] > py[1]) ? py[0] : py[1]) < ((py[2] < py[3]) ? py[2] : py[3]) ||
            ((py[2] > py[3]) ? py[2] : py[3]) < ((py[0] < py[1]) ? py[0] : py[1]) ||
            ((px[2] > px[3]) ? px[2] : px[3]) < ((px[0] < px[1]) ? px[0] : px[1]))
            return m;
        dax = px[1] - px[0]; day = py[1] - py[0];
        dbx = px[3] - px[2]; dby = py[3] - py[2];
        den = cross2(dax, day, dbx, dby);
        if (den != 0) begin
            ex = px[2] - px[0]; ey = py[2] - py[0];
            tn = cross2(ex, ey, dbx, dby);
            un = cross2(ex, ey, dax, day);
            if (den < 0) begin
                den = -den; tn = -tn; un = -un;
            end
            if (tn >= 0 && tn <= den && un >= 0 && un <= den) begin
                m.point_count = 2'd1;
                m.first_x = crossing_coord(px[0], dax, tn, den);
                m.first_y = crossing_coord(py[0], day, tn, den);
            end
            return m;
        end
        // parallel or degenerate: endpoints on both segments, repeats dropped
        for (int i = 0; i < 4; i++) begin
            dup = 0;
            if (!on_segment(px[0], py[0], px[1], py[1], px[i], py[i]) ||
                !on_segment(px[2], py[2], px[3], py[3], px[i], py[i]))
                continue;
            for (int j = 0; j < n; j++)
                if (kx[j] == px[i] && ky[j] == py[i]) dup = 1;
            if (dup || n >= 2)
                continue;
            kx[n] = px[i]; ky[n] = py[i];
            n++;
        end
        m.point_count = 2'(n);
        if (n > 0) begin
            w = 64'(kx[0]) << FRAC; m.first_x = w[31:0];
            w = 64'(ky[0]) << FRAC; m.first_y = w[31:0];
        end
        if (n > 1) begin
            w = 64'(kx[1]) << FRAC; m.second_x = w[31:0];
            w = 64'(ky[1]) << FRAC; m.second_y = w[31:0];
        end
        return m;
    endfunction

    task automatic add_pair(longint ax0, longint ay0, longint ax1, longint ay1,
                            longint bx0, longint by0, longint bx1, longint by1,
                            bit drain = 0);
        t_job j;
        j.pair = {16'(ax0), 16'(ay0), 16'(ax1), 16'(ay1),
                  16'(bx0), 16'(by0), 16'(bx1), 16'(by1)};
        j.drain = drain;
        job_q = {job_q, j};
    endtask

    function automatic longint rnd_full();
        return longint'($signed(16'($urandom)));
    endfunction

    // Stimulus and end of run
    initial begin
        longint bx, by, dx, dy, t0, t1, t2, t3;
        int     kind;
        // directed
        add_pair(0, 0, 10, 10, 20, 20, 30, 30);                 // boxes apart
        add_pair(0, 0, 10, 10, 0, 10, 10, 0);                   // plain crossing
        add_pair(0, 0, 3, 1, 0, 1, 1, 0);                       // rational crossing
        add_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        add_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        add_pair(0, 0, 1, 0, 0, 0, 0, 1);                       // shared endpoint
        add_pair(0, 0, 10, 0, 5, 0, 5, 7);                      // T junction
        add_pair(0, 0, 10, 0, 0, 1, 10, 1);                     // parallel, apart
        add_pair(0, 0, 10, 0, 5, 0, 20, 0);                     // collinear overlap
        add_pair(0, 0, 10, 10, 0, 0, 10, 10);                   // identical
        add_pair(0, 0, 10, 10, 10, 10, 0, 0);                   // reversed
        add_pair(0, 0, 10, 0, 10, 0, 20, 0);                    // collinear touch
        add_pair(0, 0, 10, 0, 2, 0, 4, 0);                      // one inside the other
        add_pair(3, 4, 3, 4, 3, 4, 3, 4);                       // both points, same
        add_pair(3, 4, 3, 4, 0, 0, 6, 8);                       // point on segment
        add_pair(3, 4, 3, 4, 0, 0, 6, 9);                       // point off segment
        add_pair(0, 0, 1, 0, 0, 1, 2, -1);                      // crossing at the end of a, half way along b
        add_pair(0, 0, -1, 0, 0, 1, -2, -1);                    // negative direction, crossing at the end of a
        add_pair(0, 0, 3, 0, 1, 1, 1, -1);                      // third steps
        add_pair(-32768, 0, 32767, 0, -32768, 0, 32767, 0);     // extreme collinear
        add_pair(32767, 32767, -32768, -32768, 0, -1, -1, 0);
        add_pair(0, 0, 7, 3, 1, 5, 6, -9);
        // random
        for (int n = 0; n < N_RANDOM; n++) begin
            kind = $urandom_range(0, 9);
            bx = $urandom_range(0, 60000) - 30000;
            by = $urandom_range(0, 60000) - 30000;
            dx = $urandom_range(0, 16) - 8;
            dy = $urandom_range(0, 16) - 8;
            t0 = $urandom_range(0, 40) - 20; t1 = $urandom_range(0, 40) - 20;
            t2 = $urandom_range(0, 40) - 20; t3 = $urandom_range(0, 40) - 20;
            case (kind)
                0, 1: add_pair(rnd_full(), rnd_full(), rnd_full(), rnd_full(),
                               rnd_full(), rnd_full(), rnd_full(), rnd_full());
                2, 3: add_pair(bx + t0 * dx, by + t0 * dy, bx + t1 * dx, by + t1 * dy,
                               bx + t2 * dx, by + t2 * dy, bx + t3 * dx, by + t3 * dy);
                4:    add_pair(bx, by, bx, by, bx + t0 * dx, by + t0 * dy,
                               bx + t1 * dx, by + t1 * dy);
                5:    add_pair(bx + t0 * dx, by + t0 * dy, bx + t1 * dx, by + t1 * dy,
                               bx + t0 * dx + $urandom_range(0, 2) - 1, by + t0 * dy,
                               bx + t1 * dx, by + t1 * dy + $urandom_range(0, 2) - 1);
                default: add_pair(bx + t0, by + t1, bx + t2, by + t3,
                                  bx + $urandom_range(0, 40) - 20,
                                  by + $urandom_range(0, 40) - 20,
                                  bx + $urandom_range(0, 40) - 20,
                                  by + $urandom_range(0, 40) - 20);
            endcase
            // half way through, wait for the pipeline to empty before sending on
            if (n == N_RANDOM / 2)
                job_q[job_q.size() - 1].drain = 1'b1;
        end
        stim_done = 1;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (job_q.size() == 0 && !i_valid && meet_q.size() == 0);
        repeat (60) @(posedge i_clk);
        if (meet_q.size() != 0) begin
            $error("%0d expected results never arrived", meet_q.size());
            n_errors++;
        end
        $display("Checked %0d of %0d segment pairs: %0d with one point, %0d with two points.",
                 n_seen, n_sent, n_cross, n_two);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Driver: offers the head of the pending queue, with random gaps
    int send_gap = 0;
    always @(posedge i_clk) begin
        logic nv;
        nv = i_valid;
        if (i_rst_n && stim_done) begin
            if (i_valid && !o_stall) begin
                meet_q = {meet_q, predict_meet(cur)};
                n_sent++;
                nv = 0;
                send_gap = ((n_sent / 150) % 2) ? 0 : $urandom_range(0, 10);
            end
            if (!nv) begin
                if (send_gap > 0)
                    send_gap--;
                else if (job_q.size() > 0 &&
                         (!job_q[0].drain || (meet_q.size() == 0 && !o_valid))) begin
                    cur <= job_q.pop_front().pair;
                    nv = 1;
                end
            end
        end
        i_valid <= nv;
    end

    // Monitor: random back-pressure and field checks
    int hold = 0;
    always @(posedge i_clk) begin
        t_meet e;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (meet_q.size() == 0) begin
                    $error("result with no transaction outstanding");
                    n_errors++;
                end else begin
                    e = meet_q.pop_front();
                    if (o_point_count !== e.point_count) begin
                        $error("point_count expected %0d got %0d", e.point_count,
                               o_point_count);
                        n_errors++;
                    end
                    if (o_first_x !== e.first_x) begin
                        $error("first_x expected %h got %h", e.first_x, o_first_x);
                        n_errors++;
                    end
                    if (o_first_y !== e.first_y) begin
                        $error("first_y expected %h got %h", e.first_y, o_first_y);
                        n_errors++;
                    end
                    if (o_second_x !== e.second_x) begin
                        $error("second_x expected %h got %h", e.second_x, o_second_x);
                        n_errors++;
                    end
                    if (o_second_y !== e.second_y) begin
                        $error("second_y expected %h got %h", e.second_y, o_second_y);
                        n_errors++;
                    end
                    if (e.point_count == 2'd2) n_two++;
                    if (e.point_count == 2'd1 && e.second_x == 0) n_cross++;
                end
                n_seen++;
                if (n_seen == 400)
                    hold = LONG_HOLD;
                else
                    hold = ((n_seen / 200) % 2) ? 0 : $urandom_range(0, 10);
            end
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

endmodule

>>> files.f
rtl/spi_pkg.sv
rtl/spi_setup.sv
rtl/spi_div.sv
rtl/spi_out.sv
rtl/segment_pair_intersection_unit.sv
test/testbench.sv
